/* rtl/core/cqe_pkg.sv */
// Shared types and constants of the circular queue engine.
package cqe_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CAP_W     = 7;
    localparam int OP_W      = 3;
    localparam int DATA_W    = 32;
    localparam int ST_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ   = 3'd0,
        OP_DEQ   = 3'd1,
        OP_PEEKF = 3'd2,
        OP_PEEKR = 3'd3,
        OP_DUMP  = 3'd4,
        OP_CLEAR = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_DUMP = 1'b1
    } bk_state_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } res_t;

    typedef struct packed {
        logic [CAP_W-1:0] count;
        logic [CAP_W-1:0] capacity;
    } bk_stat_t;

endpackage

/* rtl/core/circular_queue_engine_core.sv */
// Top level of the circular queue engine: front end, back end and result queue.
//
// Usage:
//   Input channel: present opcode and value with push; an item is taken at a
//   clock edge where push is high and full is low. Opcodes six and seven are
//   taken and dropped without a result.
//   Result channel: while empty is low, status, data and last show the oldest
//   result; pop at a clock edge takes it. last marks the final result of an item.
//   Configuration: cfg_we with cfg_data sets the capacity (saturated to 1..DEPTH)
//   and empties the queue; write only while no item is in flight.
//   Path: command queue, back-end result register, result queue, result ports.
//   Throughput: one queue operation per cycle unless results back up; a dump
//   issues one result per cycle per stored entry, paced by the single read port
//   of the slot memory, and holds later items in the command queue until it ends.
//   Reset: queue empty, capacity DEPTH, both internal queues empty; the slot
//   memory needs no clearing.
//   Stall: with pop low the result queue fills, the back end holds, then the
//   command queue fills and full rises; nothing is lost.
module circular_queue_engine_core
#(
    parameter int DEPTH = cqe_pkg::DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [cqe_pkg::OP_W-1:0]             opcode,
    input  logic signed [cqe_pkg::DATA_W-1:0]    value,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [cqe_pkg::ST_W-1:0]             status,
    output logic signed [cqe_pkg::DATA_W-1:0]    data,
    output logic                                 last,
    input  logic                                 cfg_we,
    input  logic [cqe_pkg::CAP_W-1:0]            cfg_data
);

    logic              cmd_valid;
    cqe_pkg::cmd_t     cmd;
    logic              cmd_pop;
    logic              res_valid;
    cqe_pkg::res_t     res;
    logic              res_ready;
    cqe_pkg::res_t     out_res;
    cqe_pkg::bk_stat_t stat;

    cqe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    cqe_back
    #(
        .DEPTH (DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .stat      (stat)
    );

    cqe_out_fifo u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_res   (res),
        .in_ready (res_ready),
        .empty    (empty),
        .pop      (pop),
        .out_res  (out_res)
    );

    assign status = out_res.status;
    assign data   = out_res.data;
    assign last   = out_res.last;

`ifndef SYNTHESIS
    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= stat.capacity)
        else $error("entry count above capacity");

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (stat.count == '0))
        else $error("capacity write did not empty the queue");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != cqe_pkg::ST_W'(cqe_pkg::ST_OK))) |-> (last && (data == '0)))
        else $error("error result not final or carries data");
`endif

endmodule

/* rtl/core/cqe_front.sv */
// Front end: item intake, opcode screening and the command queue to the back end.
module cqe_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [cqe_pkg::OP_W-1:0]             opcode,
    input  logic signed [cqe_pkg::DATA_W-1:0]    value,
    output logic                                 cmd_valid,
    output cqe_pkg::cmd_t                        cmd,
    input  logic                                 cmd_pop
);

    localparam int SLOTS = 2;

    cqe_pkg::cmd_t slot_reg [SLOTS];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          accept;
    logic          keep;
    logic          wr_en;
    logic          rd_en;

    assign full      = (count_reg == 2'(SLOTS));
    assign accept    = push && !full;
    assign keep      = (opcode <= cqe_pkg::OP_CLEAR);
    assign wr_en     = accept && keep;
    assign cmd_valid = (count_reg != 2'd0);
    assign rd_en     = cmd_pop && cmd_valid;
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg].op    <= cqe_pkg::op_t'(opcode);
            slot_reg[wr_ptr_reg].value <= value;
        end
    end

endmodule

/* rtl/core/cqe_back.sv */
// Back end: queue state, slot memory, command execution and dump sequencing.
module cqe_back
#(
    parameter int DEPTH = cqe_pkg::DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cqe_pkg::CAP_W-1:0]     cfg_data,
    input  logic                          cmd_valid,
    input  cqe_pkg::cmd_t                 cmd,
    output logic                          cmd_pop,
    output logic                          res_valid,
    output cqe_pkg::res_t                 res,
    input  logic                          res_ready,
    output cqe_pkg::bk_stat_t             stat
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = cqe_pkg::CAP_W;

    logic signed [cqe_pkg::DATA_W-1:0] mem [DEPTH];

    cqe_pkg::bk_state_t                state_reg, state_next;
    logic [IDX_W-1:0]                  front_reg, front_next;
    logic [IDX_W-1:0]                  rear_reg, rear_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     cap_reg, cap_next;
    logic [IDX_W-1:0]                  dump_idx_reg, dump_idx_next;
    logic [CW-1:0]                     left_reg, left_next;

    logic                              r_valid_reg, r_valid_next;
    cqe_pkg::status_t                  r_status_reg;
    logic                              r_last_reg;
    logic                              r_rd_reg;
    logic signed [cqe_pkg::DATA_W-1:0] rd_data_reg;

    logic                              adv;
    logic                              issue_valid;
    cqe_pkg::status_t                  issue_status;
    logic                              issue_last;
    logic                              issue_rd;
    logic [IDX_W-1:0]                  rd_addr;
    logic                              mem_we;
    logic [IDX_W-1:0]                  mem_waddr;
    logic [CW-1:0]                     cap_sat;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                  input logic [CW-1:0] cap);
        logic [IDX_W:0] n;
        n = {1'b0, idx} + (IDX_W+1)'(1);
        if (CW'(n) >= cap)
            return '0;
        return n[IDX_W-1:0];
    endfunction

    assign adv       = !r_valid_reg || res_ready;
    assign res_valid = r_valid_reg;
    assign stat      = '{count: count_reg, capacity: cap_reg};

    always_comb
    begin
        res.status = r_status_reg;
        res.data   = r_rd_reg ? rd_data_reg : '0;
        res.last   = r_last_reg;
    end

    always_comb
    begin
        if (cfg_data == '0)
            cap_sat = CW'(1);
        else if (cfg_data > CW'(DEPTH))
            cap_sat = CW'(DEPTH);
        else
            cap_sat = cfg_data;
    end

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        rear_next     = rear_reg;
        count_next    = count_reg;
        cap_next      = cap_reg;
        dump_idx_next = dump_idx_reg;
        left_next     = left_reg;
        cmd_pop       = 1'b0;
        issue_valid   = 1'b0;
        issue_status  = cqe_pkg::ST_OK;
        issue_last    = 1'b1;
        issue_rd      = 1'b0;
        rd_addr       = front_reg;
        mem_we        = 1'b0;
        mem_waddr     = next_idx(rear_reg, cap_reg);

        unique case (state_reg)
            cqe_pkg::BK_IDLE:
            begin
                if (cmd_valid && adv)
                begin
                    cmd_pop     = 1'b1;
                    issue_valid = 1'b1;
                    unique case (cmd.op)
                        cqe_pkg::OP_ENQ:
                        begin
                            if (count_reg >= cap_reg)
                                issue_status = cqe_pkg::ST_FULL;
                            else
                            begin
                                rear_next  = mem_waddr;
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        cqe_pkg::OP_DEQ:
                        begin
                            if (count_reg == '0)
                                issue_status = cqe_pkg::ST_EMPTY;
                            else
                            begin
                                front_next = next_idx(front_reg, cap_reg);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        cqe_pkg::OP_PEEKF, cqe_pkg::OP_PEEKR:
                        begin
                            if (count_reg == '0)
                                issue_status = cqe_pkg::ST_EMPTY;
                            else
                            begin
                                issue_rd = 1'b1;
                                rd_addr  = (cmd.op == cqe_pkg::OP_PEEKF) ? front_reg
                                                                         : rear_reg;
                            end
                        end
                        cqe_pkg::OP_DUMP:
                        begin
                            if (count_reg == '0)
                                issue_status = cqe_pkg::ST_EMPTY;
                            else
                            begin
                                issue_rd = 1'b1;
                                if (count_reg != CW'(1))
                                begin
                                    issue_last    = 1'b0;
                                    dump_idx_next = next_idx(front_reg, cap_reg);
                                    left_next     = count_reg - CW'(1);
                                    state_next    = cqe_pkg::BK_DUMP;
                                end
                            end
                        end
                        cqe_pkg::OP_CLEAR:
                        begin
                            front_next = '0;
                            rear_next  = IDX_W'(cap_reg - CW'(1));
                            count_next = '0;
                        end
                        default:
                        begin
                            issue_valid = 1'b0;
                        end
                    endcase
                end
            end
            cqe_pkg::BK_DUMP:
            begin
                if (adv)
                begin
                    issue_valid   = 1'b1;
                    issue_rd      = 1'b1;
                    rd_addr       = dump_idx_reg;
                    issue_last    = (left_reg == CW'(1));
                    dump_idx_next = next_idx(dump_idx_reg, cap_reg);
                    left_next     = left_reg - CW'(1);
                    if (left_reg == CW'(1))
                        state_next = cqe_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = cqe_pkg::BK_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            cap_next   = cap_sat;
            front_next = '0;
            rear_next  = IDX_W'(cap_sat - CW'(1));
            count_next = '0;
        end

        r_valid_next = adv ? issue_valid : r_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cqe_pkg::BK_IDLE;
            front_reg    <= '0;
            rear_reg     <= IDX_W'(DEPTH - 1);
            count_reg    <= '0;
            cap_reg      <= CW'(DEPTH);
            dump_idx_reg <= '0;
            left_reg     <= '0;
            r_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            rear_reg     <= rear_next;
            count_reg    <= count_next;
            cap_reg      <= cap_next;
            dump_idx_reg <= dump_idx_next;
            left_reg     <= left_next;
            r_valid_reg  <= r_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_status_reg <= issue_status;
            r_last_reg   <= issue_last;
            r_rd_reg     <= issue_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= cmd.value;
    end

    always_ff @(posedge clk)
    begin
        if (adv && issue_rd)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

/* rtl/core/cqe_out_fifo.sv */
// Result queue: two-entry buffer between the back end and the result ports.
module cqe_out_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  cqe_pkg::res_t  in_res,
    output logic           in_ready,
    output logic           empty,
    input  logic           pop,
    output cqe_pkg::res_t  out_res
);

    localparam int SLOTS = 2;

    cqe_pkg::res_t slot_reg [SLOTS];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          wr_en;
    logic          rd_en;

    assign in_ready = (count_reg != 2'(SLOTS));
    assign empty    = (count_reg == 2'd0);
    assign wr_en    = in_valid && in_ready;
    assign rd_en    = pop && !empty;
    assign out_res  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= in_res;
    end

endmodule
